// ===== rtl/core/lkcr_pkg.sv =====
// Shared types and constants for the looping keyframe color ramp.
// Holds the request and result beat structs, the keyframe entry layout and
// the register and request codes; depends on nothing else.
package lkcr_pkg;

  localparam int MAX_KEYFRAMES = 16;
  localparam int IDX_W         = $clog2(MAX_KEYFRAMES);
  localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 1);
  localparam int DUR_W         = 16;
  localparam int TOT_W         = DUR_W + IDX_W;
  localparam int COL_W         = 8;
  localparam int NUM_CH        = 4;
  localparam int TIME_W        = 32;
  localparam int DVD_W         = TIME_W + 1;
  localparam int NUM_W         = COL_W + DUR_W;
  localparam int SCNT_W        = 5;
  localparam int SEG_W         = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY = 1'b1;

  // Channel 0 is red, then green, blue and alpha.
  typedef logic [NUM_CH-1:0][COL_W-1:0] color_t;

  typedef struct packed {
    color_t             color;
    logic [DUR_W-1:0]   dur;
  } kf_entry_t;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         entry_index;
    logic [COL_W-1:0]   red_in;
    logic [COL_W-1:0]   green_in;
    logic [COL_W-1:0]   blue_in;
    logic [COL_W-1:0]   alpha_in;
    logic [DUR_W-1:0]   seg_duration;
    logic [TIME_W-1:0]  time_now;
  } lkcr_in_t;

  typedef struct packed {
    logic [COL_W-1:0]   red_out;
    logic [COL_W-1:0]   green_out;
    logic [COL_W-1:0]   blue_out;
    logic [COL_W-1:0]   alpha_out;
    logic [SEG_W-1:0]   segment_found;
  } lkcr_out_t;

endpackage

// ===== rtl/core/looping_keyframe_color_ramp.sv =====
// Looping keyframe color ramp: keyframe table memory, loop phase and blend.
// Depends on lkcr_pkg for beat structs, entry layout and codes.
//
//   channel   handshake              payload          direction
//   in        start / busy           in_data          into block
//   out       out_valid (strobe)     out_data         out of block
//   cfg       cfg_valid / cfg_ready  cfg_index, data  into block
//
// A write beat gives no result; the next beat may follow.
// An evaluate beat walks the table memory (one entry per cycle) to sum the
// durations, runs a 33-step remainder, walks the table again up to the hit
// segment, then does an 8-step division on all four channels at once (skipped
// if that segment's duration is zero). A degenerate ramp ends after the sum.
// busy is high throughout, but stays low when no keyframes are in use.
// Reset is synchronous; the table holds garbage until written. Each result
// stands for one cycle and cannot be stalled.
module looping_keyframe_color_ramp
  import lkcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lkcr_in_t              in_data,
  output logic                  out_valid,
  output lkcr_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_NEXT = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  localparam int BCNT_W = $clog2(DVD_W);
  localparam int DCNT_W = $clog2(COL_W);

  // Keyframe table memory.
  kf_entry_t        kf_mem [MAX_KEYFRAMES];
  kf_entry_t        rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  kf_entry_t        wr_entry;

  // Control and datapath registers.
  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic [DVD_W-1:0]        dvd_r, dvd_nxt;
  logic [TOT_W-1:0]        rem_r, rem_nxt;
  logic [BCNT_W-1:0]       bcnt_r, bcnt_nxt;
  logic [TOT_W-1:0]        run_r, run_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [DUR_W-1:0]        d_r, d_nxt;
  logic [DUR_W-1:0]        left_r, left_nxt;
  color_t                  colk_r, colk_nxt;
  color_t                  col0_r, col0_nxt;
  logic [NUM_CH-1:0][NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0]        dsh_r, dsh_nxt;
  color_t                  q_r, q_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  color_t                  cur_color_r, cur_color_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lkcr_out_t               out_data_r, out_data_nxt;
  logic [SCNT_W-1:0]       state_count_r;
  logic [TIME_W-1:0]       phase_delay_r;

  // Combinational helpers.
  logic [CNT_W-1:0]  n_act;
  logic              accept;
  logic              last;
  logic [IDX_W-1:0]  nxt_idx;
  logic [TOT_W-1:0]  tot_sum;
  logic [TOT_W-1:0]  run_sum;
  logic [TOT_W-1:0]  diff;
  logic              found;
  logic [TOT_W:0]    trial;
  logic              emit_en;
  color_t            emit_col;
  logic [IDX_W-1:0]  emit_seg;
  logic              ge;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_act = (32'(state_count_r) > MAX_KEYFRAMES) ? CNT_W'(MAX_KEYFRAMES)
                                                      : CNT_W'(state_count_r);

  assign wr_en   = accept && (in_data.req_type == REQ_WRITE) &&
                   (32'(in_data.entry_index) < MAX_KEYFRAMES);
  assign wr_addr = IDX_W'(in_data.entry_index);
  assign wr_entry.color = {in_data.alpha_in, in_data.blue_in,
                           in_data.green_in, in_data.red_in};
  assign wr_entry.dur   = in_data.seg_duration;

  // Writes happen only from idle. A read issued in the same cycle is used only
  // when an evaluate beat is accepted, which never coincides with a write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kf_mem[wr_addr] <= wr_entry;
    end
    rd_data <= kf_mem[rd_addr];
  end

  assign last    = ((CNT_W'(idx_r) + CNT_W'(1)) == n_act);
  assign nxt_idx = last ? '0 : idx_r + IDX_W'(1);
  assign tot_sum = total_r + TOT_W'(rd_data.dur);
  assign run_sum = run_r + TOT_W'(rd_data.dur);
  assign diff    = run_sum - rem_r;
  assign found   = (run_sum >= rem_r) || last;
  assign trial   = {rem_r, dvd_r[DVD_W-1]};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bcnt_nxt      = bcnt_r;
    run_nxt       = run_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    left_nxt      = left_r;
    colk_nxt      = colk_r;
    col0_nxt      = col0_r;
    num_nxt       = num_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    rd_addr       = '0;
    emit_en       = 1'b0;
    emit_col      = cur_color_r;
    emit_seg      = '0;
    ge            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.req_type == REQ_EVAL)) begin
          if (n_act == '0) begin
            emit_en = 1'b1;
          end else begin
            state_nxt = S_SUM;
            idx_nxt   = '0;
            total_nxt = '0;
            dvd_nxt   = DVD_W'(in_data.time_now) + DVD_W'(phase_delay_r);
          end
        end
      end
      S_SUM: begin
        total_nxt = tot_sum;
        idx_nxt   = idx_r + IDX_W'(1);
        rd_addr   = idx_r + IDX_W'(1);
        if (idx_r == '0) begin
          col0_nxt = rd_data.color;
        end
        if (last) begin
          if ((n_act == CNT_W'(1)) || (tot_sum == '0)) begin
            emit_en   = 1'b1;
            emit_col  = (idx_r == '0) ? rd_data.color : col0_r;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MOD;
            rem_nxt   = '0;
            bcnt_nxt  = BCNT_W'(DVD_W - 1);
          end
        end
      end
      S_MOD: begin
        // Restoring remainder, one dividend bit per cycle, MSB first.
        if (trial >= {1'b0, total_r}) begin
          rem_nxt = TOT_W'(trial - {1'b0, total_r});
        end else begin
          rem_nxt = TOT_W'(trial);
        end
        dvd_nxt  = dvd_r << 1;
        bcnt_nxt = bcnt_r - BCNT_W'(1);
        if (bcnt_r == '0) begin
          state_nxt = S_WALK;
          idx_nxt   = '0;
          run_nxt   = '0;
        end
      end
      S_WALK: begin
        run_nxt = run_sum;
        idx_nxt = nxt_idx;
        rd_addr = nxt_idx;
        if (found) begin
          k_nxt    = idx_r;
          d_nxt    = rd_data.dur;
          colk_nxt = rd_data.color;
          // Only the first segment at phase zero can reach its full length.
          left_nxt = (diff > TOT_W'(rd_data.dur)) ? rd_data.dur
                                                   : DUR_W'(diff);
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (d_r == '0) begin
          emit_en   = 1'b1;
          emit_col  = rd_data.color;
          emit_seg  = k_r;
          state_nxt = S_IDLE;
        end else begin
          for (int c = 0; c < NUM_CH; c++) begin
            num_nxt[c] = NUM_W'(left_r) * NUM_W'(colk_r[c]) +
                         NUM_W'(d_r - left_r) * NUM_W'(rd_data.color[c]);
          end
          dsh_nxt   = NUM_W'(d_r) << (COL_W - 1);
          dcnt_nxt  = DCNT_W'(COL_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // The blend never exceeds 255 times the divisor, so eight quotient
        // bits are enough.
        for (int c = 0; c < NUM_CH; c++) begin
          ge = (num_r[c] >= dsh_r);
          if (ge) begin
            num_nxt[c] = num_r[c] - dsh_r;
          end
          q_nxt[c] = {q_r[c][COL_W-2:0], ge};
        end
        dsh_nxt  = dsh_r >> 1;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          emit_en   = 1'b1;
          emit_col  = q_nxt;
          emit_seg  = k_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit_en;
    cur_color_nxt = emit_en ? emit_col : cur_color_r;
    out_data_nxt.red_out       = emit_col[0];
    out_data_nxt.green_out     = emit_col[1];
    out_data_nxt.blue_out      = emit_col[2];
    out_data_nxt.alpha_out     = emit_col[3];
    out_data_nxt.segment_found = SEG_W'(emit_seg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      cur_color_r   <= '1;
      state_count_r <= '0;
      phase_delay_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_color_r <= cur_color_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STATE_COUNT: state_count_r <= SCNT_W'(cfg_data);
          CFG_PHASE_DELAY: phase_delay_r <= TIME_W'(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    total_r    <= total_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    bcnt_r     <= bcnt_nxt;
    run_r      <= run_nxt;
    k_r        <= k_nxt;
    d_r        <= d_nxt;
    left_r     <= left_nxt;
    colk_r     <= colk_nxt;
    col0_r     <= col0_nxt;
    num_r      <= num_nxt;
    dsh_r      <= dsh_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    if (out_valid_nxt) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is only produced while the block is idle.
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the block is busy");

  // Keyframe writes never produce a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.req_type == REQ_WRITE)) |=> !out_valid)
    else $error("write beat produced a result");

  // The segment walk stays inside the keyframes in use.
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (CNT_W'(idx_r) < n_act))
    else $error("segment walk ran past the active keyframes");

  // The loop phase is always below the total length once it is used.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (rem_r < total_r))
    else $error("loop phase not below total length");
`endif

endmodule
